// File: rtl/masked_centered_moving_average_core_macros.svh
// Assertion macros used by the masked centered moving average core.
`ifndef MASKED_CENTERED_MOVING_AVERAGE_CORE_MACROS_SVH
`define MASKED_CENTERED_MOVING_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MCMA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("masked moving average: implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MCMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("masked moving average: next-cycle check failed");

`endif

// File: rtl/mcma_pkg.sv
// Shared types and constants of the masked centered moving average core.
`timescale 1ns / 1ps

package mcma_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CHECK_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT    = 2'd3;

  // Reset values of the registers.
  localparam logic [WIN_W-1:0]           WIN_LENGTH_RST  = 5'd7;
  localparam logic signed [SAMPLE_W-1:0] LOWER_LIMIT_RST = -32'sd327680;
  localparam logic signed [SAMPLE_W-1:0] UPPER_LIMIT_RST = 32'sd2621440;

  // Smallest usable window.
  localparam logic [WIN_W-1:0] WIN_MIN = 5'd3;

  // Missing-value markers -999.0 and -9999.0 in Q15.16.
  localparam logic signed [SAMPLE_W-1:0] MISSING_A = -32'sd65470464;
  localparam logic signed [SAMPLE_W-1:0] MISSING_B = -32'sd655294464;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_not_number;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       was_averaged;
    logic                       last_result;
  } out_item_t;

  // One stored sample: validity judged on arrival, then the raw value.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] value;
  } entry_t;

endpackage

// File: rtl/mcma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mcma_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 31
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mcma_div.sv
// Restoring serial divider: signed sum by unsigned count, truncating toward zero.
`timescale 1ns / 1ps

module mcma_div #(
  parameter int SUM_W = 37,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           dividend,
  input  logic [CNT_W-1:0]                  divisor,
  output logic                              done,
  output logic [mcma_pkg::SAMPLE_W-1:0]     quotient
);
  import mcma_pkg::*;

  localparam int IW = $clog2(SUM_W + 1);

  logic             busy;
  logic [IW-1:0]    iter;
  logic [CNT_W:0]   rem;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] dvs;
  logic             neg;
  logic [CNT_W:0]   shifted;
  logic [CNT_W+1:0] trial;
  logic [SUM_W-1:0] q_signed;

  // One quotient bit per cycle, most significant first.
  assign shifted  = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dvs};
  assign q_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient = q_signed[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= IW'(SUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == IW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[CNT_W+1]) begin
        rem <= trial[CNT_W:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/masked_centered_moving_average_core.sv
// Top level of the masked centered moving average core.
// Sequence: once its word is taken, a result's hi + 1 samples are read one per cycle, the read
//   port drains, the sum goes to the serial divider, and the result word is then registered.
// Input: one word at a time; a word that owes no result is taken without a stall, while other
//   words stall the input until their results are emitted, every flushed result for a last word.
// Reset: synchronous, active high; registers take their defaults, the sample RAM is kept.
`timescale 1ns / 1ps

module masked_centered_moving_average_core #(
  parameter int MAX_WINDOW = 31
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  mcma_pkg::in_item_t                    in_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output mcma_pkg::out_item_t                   out_word,
  input  logic                                  cfg_we,
  input  logic [mcma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcma_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mcma_pkg::*;

`include "masked_centered_moving_average_core_macros.svh"

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int EW = SAMPLE_W + 1;
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST_ADR = AW'(MAX_WINDOW - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  // Configuration registers.
  logic [WIN_W-1:0]           win_length;
  logic                       range_check_on;
  logic signed [SAMPLE_W-1:0] lower_limit;
  logic signed [SAMPLE_W-1:0] upper_limit;

  // Sequencer state.
  state_t              state;
  logic [AW-1:0]       head;
  logic [CW-1:0]       samples_buffered;
  logic [CW-1:0]       cur_age;
  logic [CW-1:0]       k_reg;
  logic [CW-1:0]       item_n_m1;
  logic                item_last;
  logic [CW-1:0]       scan_a;
  logic                use_mean;

  // Accumulator fed from the RAM read port in the cycle after each address.
  logic                       acc_en;
  logic                       acc_hit;
  logic signed [SW-1:0]       acc_sum;
  logic [CW-1:0]              acc_cnt;
  logic [SAMPLE_W-1:0]        cap_value;

  logic                in_fire;
  logic                emit_go;
  logic                win_usable;
  logic [CW-1:0]       win_cnt;
  logic [CW-1:0]       k_cnt;
  logic [CW-1:0]       n_next;
  logic [CW-1:0]       nm1;
  logic [CW-1:0]       top_age;
  logic [CW:0]         hi_ext;
  logic [CW-1:0]       hi;
  logic [AW-1:0]       head_next;
  logic [AW-1:0]       scan_adr;
  logic [AW:0]         wrap_adr;
  logic                sample_ok;
  logic                more_results;
  entry_t              wr_entry;
  entry_t              rd_entry;
  logic [EW-1:0]       ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quot;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign emit_go  = (state == ST_EMIT) && (!out_valid || !out_stall);

  // A window is usable only when odd, at least three and within the store.
  assign win_usable = (win_length >= WIN_MIN) && win_length[0] &&
                      (int'(win_length) <= MAX_WINDOW);
  assign win_cnt = CW'(win_length);
  assign k_cnt   = CW'(win_length >> 1);

  // Sequence fill count after this word, saturating at the window length.
  assign n_next  = (samples_buffered < win_cnt) ? CW'(samples_buffered + 1'b1)
                                                : samples_buffered;
  assign nm1     = n_next - 1'b1;
  assign top_age = (nm1 < k_cnt) ? nm1 : k_cnt;

  // The window of the sample at cur_age always starts at the newest sample, since
  // cur_age never exceeds k; it ends k samples further back or at the oldest one held.
  assign hi_ext = {1'b0, cur_age} + {1'b0, k_reg};
  assign hi     = (hi_ext > {1'b0, item_n_m1}) ? item_n_m1 : hi_ext[CW-1:0];

  // The store is a ring: age a lives a slots behind the head.
  assign head_next = (head == LAST_ADR) ? '0 : head + 1'b1;
  assign wrap_adr  = {1'b0, head} + DEPTH_X - {1'b0, scan_a[AW-1:0]};
  assign scan_adr  = (head >= scan_a[AW-1:0]) ? (head - scan_a[AW-1:0])
                                              : wrap_adr[AW-1:0];

  // Validity is judged once, against the registers as they are on arrival.
  assign sample_ok = !in_word.sample_not_number &&
                     (in_word.sample_value != MISSING_A) &&
                     (in_word.sample_value != MISSING_B) &&
                     !(range_check_on && ((in_word.sample_value < lower_limit) ||
                                          (in_word.sample_value > upper_limit)));

  assign wr_entry.valid = sample_ok;
  assign wr_entry.value = in_word.sample_value;
  assign rd_entry       = ram_rdata;

  assign more_results = item_last && (cur_age != '0);
  assign div_start    = (state == ST_DIV) && (acc_cnt != '0);

  mcma_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (in_fire && win_usable),
    .waddr (head_next),
    .wdata (wr_entry),
    .raddr (scan_adr),
    .rdata (ram_rdata)
  );

  mcma_div #(
    .SUM_W (SW),
    .CNT_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (acc_cnt),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Control: sequencer, fill count, ring head and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      head             <= '0;
      samples_buffered <= '0;
      acc_en           <= 1'b0;
      acc_hit          <= 1'b0;
      out_valid        <= 1'b0;
      win_length       <= WIN_LENGTH_RST;
      range_check_on   <= 1'b1;
      lower_limit      <= LOWER_LIMIT_RST;
      upper_limit      <= UPPER_LIMIT_RST;
    end else begin
      acc_en  <= (state == ST_SCAN);
      acc_hit <= (state == ST_SCAN) && (scan_a == cur_age);

      // A new result word replaces the one on offer as it is taken.
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // A new window length drops the sequence in progress.
      if (cfg_we && (cfg_index == REG_WIN_LENGTH)) begin
        samples_buffered <= '0;
      end else if (in_fire && win_usable) begin
        samples_buffered <= in_word.last_sample ? '0 : n_next;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (!win_usable) begin
              state <= ST_EMIT;
            end else begin
              head <= head_next;
              // A middle word yields a result once more than k samples are held.
              if (in_word.last_sample || (n_next > k_cnt)) begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_a == hi) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= (acc_cnt != '0) ? ST_WAIT : ST_EMIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= more_results ? ST_SCAN : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          REG_WIN_LENGTH: begin
            win_length <= cfg_data[WIN_W-1:0];
          end
          REG_RANGE_CHECK_ON: begin
            range_check_on <= cfg_data[0];
          end
          REG_LOWER_LIMIT: begin
            lower_limit <= cfg_data[SAMPLE_W-1:0];
          end
          REG_UPPER_LIMIT: begin
            upper_limit <= cfg_data[SAMPLE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath: per-word context, scan index, accumulator and the output word.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          item_last <= in_word.last_sample;
          scan_a    <= '0;
          acc_sum   <= '0;
          acc_cnt   <= '0;
          if (!win_usable) begin
            cap_value <= in_word.sample_value;
            use_mean  <= 1'b0;
            cur_age   <= '0;
          end else begin
            item_n_m1 <= nm1;
            k_reg     <= k_cnt;
            cur_age   <= in_word.last_sample ? top_age : k_cnt;
          end
        end
      end
      ST_SCAN: begin
        scan_a <= scan_a + 1'b1;
      end
      ST_DIV: begin
        use_mean <= (acc_cnt != '0);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_word.filtered_value <= use_mean ? div_quot : cap_value;
          out_word.was_averaged   <= use_mean;
          out_word.last_result    <= item_last && (cur_age == '0);
          if (more_results) begin
            cur_age <= cur_age - 1'b1;
            scan_a  <= '0;
            acc_sum <= '0;
            acc_cnt <= '0;
          end
        end
      end
      default: begin
      end
    endcase

    // Read data arrives in the cycle after its address; the sample at the
    // result's own age is kept in case the window holds no valid sample.
    if (acc_en && rd_entry.valid) begin
      acc_sum <= acc_sum + {{CW{rd_entry.value[SAMPLE_W-1]}}, rd_entry.value};
      acc_cnt <= acc_cnt + 1'b1;
    end
    if (acc_hit) begin
      cap_value <= rd_entry.value;
    end
  end

  // The valid count of a finished scan never exceeds the samples scanned.
  `MCMA_ASSERT_IMPLY(a_cnt_bound, clk, rst, state == ST_DIV, acc_cnt <= hi + 1'b1)

  // The divider only reports completion while the sequencer waits for it.
  `MCMA_ASSERT_IMPLY(a_div_done_wait, clk, rst, div_done, state == ST_WAIT)

  // A scan never reaches past the window or serves an age beyond half the window.
  `MCMA_ASSERT_IMPLY(a_scan_bound, clk, rst, state == ST_SCAN, (cur_age <= k_reg) && (scan_a <= hi))

  // After the final result of a word the block is idle with that result on offer.
  `MCMA_ASSERT_NEXT(a_emit_idle, clk, rst, emit_go && !more_results, (state == ST_IDLE) && out_valid)

endmodule
